### sv/ypfm_pkg.sv
// ----------------------------------------------------------------------------
// ypfm_pkg
// Shared constants, codes and a helper function for the yaw PID four-motor
// mixer.
// ----------------------------------------------------------------------------
package ypfm_pkg;

  localparam int OP_W      = 3;
  localparam int YAW_W     = 16;
  localparam int TGT_W     = 10;
  localparam int SPEED_W   = 8;
  localparam int GAIN_W    = 16;
  localparam int CORR_W    = 10;
  localparam int DUTY_W    = 8;
  localparam int ERR_W     = 17;
  localparam int SUM_W     = 32;
  localparam int DIFF_W    = 18;
  localparam int PPROD_W   = 34;
  localparam int IPROD_W   = 49;
  localparam int DPROD_W   = 35;
  localparam int ACC_W     = 51;
  localparam int FRAC_W    = 16;
  localparam int CMD_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic [OP_W-1:0] OP_FORWARD  = 3'd0;
  localparam logic [OP_W-1:0] OP_BACKWARD = 3'd1;
  localparam logic [OP_W-1:0] OP_RIGHT    = 3'd2;
  localparam logic [OP_W-1:0] OP_LEFT     = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd2;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd4588;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd0;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd655;

  localparam logic signed [CORR_W-1:0] CORR_MAX = 10'sd511;
  localparam logic signed [CORR_W-1:0] CORR_MIN = -10'sd511;
  localparam logic signed [CMD_W-1:0]  CMD_MAX  = 12'sd255;
  localparam logic signed [CMD_W-1:0]  CMD_MIN  = -12'sd255;
  localparam logic signed [CMD_W-1:0]  CMD_STOP = 12'sd1;
  localparam logic [DUTY_W-1:0]        DUTY_FULL = 8'd255;

  // {duty, dir} for one motor; dir_pos is the pin level for a positive command
  function automatic logic [DUTY_W:0] motor_drive(input logic signed [CMD_W-1:0] cmd,
                                                  input logic dir_pos);
    logic signed [CMD_W-1:0] clamped;
    logic [DUTY_W-1:0]       mag;
    logic                    pos;
    begin
      clamped = cmd;
      if (cmd > CMD_MAX) clamped = CMD_MAX;
      if (cmd < CMD_MIN) clamped = CMD_MIN;
      pos = (cmd > 12'sd0);
      mag = clamped[CMD_W-1] ? DUTY_W'(-clamped) : DUTY_W'(clamped);
      return {DUTY_FULL - mag, ~(pos ^ dir_pos)};
    end
  endfunction

endpackage

### sv/yaw_pid_four_motor_mixer_unit.sv
// ----------------------------------------------------------------------------
// yaw_pid_four_motor_mixer_unit
// Heading PID with saturating integral, floored correction and four-wheel
// motor mixing into direction pins and inverted duties.
// ----------------------------------------------------------------------------
// Four-stage pipeline: input register, product register (error, integral
// update and the three gain multiplies), correction register (sum, floor,
// saturate) and result register (mixing and motor drive). One word is taken
// per cycle while in_tready is high. Integral and previous error are updated,
// for drive operations only, as a word leaves the input register, so
// successive words see each other's state with no gap. Each stage holds only
// while the stage after it is full and stalled. Gains are written through the
// cfg port, which is always ready; write them only while the pipeline is empty.
module yaw_pid_four_motor_mixer_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [15:0] yaw_tenths, [25:16] target_deg, [33:26] base_speed, rest zero
  input  logic [ypfm_pkg::IN_DATA_W-1:0]       in_tdata,
  // [2:0] operation
  input  logic [ypfm_pkg::OP_W-1:0]            in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [9:0] correction, [10] m1_dir, [18:11] m1_duty, [19] m2_dir,
  // [27:20] m2_duty, [28] m3_dir, [36:29] m3_duty, [37] m4_dir,
  // [45:38] m4_duty, rest zero
  output logic [ypfm_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ypfm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ypfm_pkg::GAIN_W-1:0]          cfg_data
);
  import ypfm_pkg::*;

  // configuration
  logic [GAIN_W-1:0] prop_gain_r, integ_gain_r, deriv_gain_r;

  // pipeline valids and enables
  logic v0_r, v1_r, v2_r, out_valid_r;
  logic en0, en1, en2, en3;

  // stage 0: input register
  logic [OP_W-1:0]                s0_op_r;
  logic signed [YAW_W-1:0]        s0_yaw_r;
  logic signed [TGT_W-1:0]        s0_tgt_r;
  logic [SPEED_W-1:0]             s0_speed_r;

  // PID state
  logic signed [SUM_W-1:0]        error_sum_r, error_sum_nxt;
  logic signed [ERR_W-1:0]        last_error_r;

  // stage 1: products
  logic [OP_W-1:0]                s1_op_r;
  logic [SPEED_W-1:0]             s1_speed_r;
  logic signed [PPROD_W-1:0]      s1_pprod_r, pprod_nxt;
  logic signed [IPROD_W-1:0]      s1_iprod_r, iprod_nxt;
  logic signed [DPROD_W-1:0]      s1_dprod_r, dprod_nxt;

  // stage 2: correction
  logic [OP_W-1:0]                s2_op_r;
  logic [SPEED_W-1:0]             s2_speed_r;
  logic signed [CORR_W-1:0]       s2_corr_r, corr_nxt;

  // result
  logic [OUT_DATA_W-1:0]          out_data_r, out_data_nxt;

  logic signed [ERR_W-1:0]        tgt_x10, err_w;
  logic signed [SUM_W:0]          sum_w;
  logic signed [DIFF_W-1:0]       diff_w;
  logic signed [ACC_W-1:0]        acc_w;
  logic signed [ACC_W-FRAC_W-1:0] quot_w;
  logic                           drive_op;
  logic signed [CMD_W-1:0]        spd_x, corr_x, s_minus_p, s_plus_p;
  logic signed [CMD_W-1:0]        c1, c2, c3, c4;
  logic signed [CORR_W-1:0]       corr_out;

  assign en3       = !out_valid_r || out_tready;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign en0       = !v0_r || en1;
  assign in_tready = en0;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign drive_op = (s0_op_r == OP_FORWARD) || (s0_op_r == OP_BACKWARD) ||
                    (s0_op_r == OP_RIGHT) || (s0_op_r == OP_LEFT);

  // stage 1 combinational: error, saturating integral, products
  always_comb begin
    tgt_x10 = ERR_W'(s0_tgt_r) * 17'sd10;
    err_w   = tgt_x10 - ERR_W'(s0_yaw_r);
    sum_w   = (SUM_W+1)'(error_sum_r) + (SUM_W+1)'(err_w);
    error_sum_nxt = sum_w[SUM_W-1:0];
    if (sum_w[SUM_W] != sum_w[SUM_W-1]) begin
      error_sum_nxt = sum_w[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    diff_w    = DIFF_W'(err_w) - DIFF_W'(last_error_r);
    pprod_nxt = PPROD_W'($signed({1'b0, prop_gain_r})) * PPROD_W'(err_w);
    iprod_nxt = IPROD_W'($signed({1'b0, integ_gain_r})) * IPROD_W'(error_sum_nxt);
    dprod_nxt = DPROD_W'($signed({1'b0, deriv_gain_r})) * DPROD_W'(diff_w);
  end

  // stage 2 combinational: sum, floor, saturate
  always_comb begin
    acc_w  = ACC_W'(s1_pprod_r) + ACC_W'(s1_iprod_r) + ACC_W'(s1_dprod_r);
    quot_w = acc_w[ACC_W-1:FRAC_W];
    if (quot_w > (ACC_W-FRAC_W)'(CORR_MAX)) begin
      corr_nxt = CORR_MAX;
    end else if (quot_w < (ACC_W-FRAC_W)'(CORR_MIN)) begin
      corr_nxt = CORR_MIN;
    end else begin
      corr_nxt = quot_w[CORR_W-1:0];
    end
  end

  // stage 3 combinational: mixing and drive
  always_comb begin
    spd_x     = $signed({{(CMD_W-SPEED_W){1'b0}}, s2_speed_r});
    corr_x    = CMD_W'(s2_corr_r);
    s_minus_p = spd_x - corr_x;
    s_plus_p  = spd_x + corr_x;
    corr_out  = s2_corr_r;
    case (s2_op_r)
      OP_FORWARD: begin
        c1 = s_minus_p;  c2 = s_plus_p;   c3 = s_plus_p;   c4 = s_minus_p;
      end
      OP_BACKWARD: begin
        c1 = -s_plus_p;  c2 = -s_minus_p; c3 = -s_minus_p; c4 = -s_plus_p;
      end
      OP_RIGHT: begin
        c1 = s_minus_p;  c2 = -s_plus_p;  c3 = s_plus_p;   c4 = -s_minus_p;
      end
      OP_LEFT: begin
        c1 = -s_plus_p;  c2 = s_minus_p;  c3 = -s_minus_p; c4 = s_plus_p;
      end
      default: begin
        c1 = CMD_STOP;   c2 = CMD_STOP;   c3 = CMD_STOP;   c4 = CMD_STOP;
        corr_out = '0;
      end
    endcase
    out_data_nxt = {2'b00,
                    motor_drive(c4, 1'b1),
                    motor_drive(c3, 1'b0),
                    motor_drive(c2, 1'b0),
                    motor_drive(c1, 1'b1),
                    corr_out};
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r         <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      error_sum_r  <= '0;
      last_error_r <= '0;
      prop_gain_r  <= PROP_GAIN_RST;
      integ_gain_r <= INTEG_GAIN_RST;
      deriv_gain_r <= DERIV_GAIN_RST;
    end else begin
      if (en0) v0_r <= in_tvalid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) out_valid_r <= v2_r;
      if (en1 && v0_r && drive_op) begin
        error_sum_r  <= error_sum_nxt;
        last_error_r <= err_w;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_PROP_GAIN:  prop_gain_r  <= cfg_data;
          REG_INTEG_GAIN: integ_gain_r <= cfg_data;
          REG_DERIV_GAIN: deriv_gain_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en0 && in_tvalid) begin
      s0_op_r    <= in_tuser;
      s0_yaw_r   <= in_tdata[15:0];
      s0_tgt_r   <= in_tdata[25:16];
      s0_speed_r <= in_tdata[33:26];
    end
    if (en1 && v0_r) begin
      s1_op_r    <= s0_op_r;
      s1_speed_r <= s0_speed_r;
      s1_pprod_r <= pprod_nxt;
      s1_iprod_r <= iprod_nxt;
      s1_dprod_r <= dprod_nxt;
    end
    if (en2 && v1_r) begin
      s2_op_r    <= s1_op_r;
      s2_speed_r <= s1_speed_r;
      s2_corr_r  <= corr_nxt;
    end
    if (en3 && v2_r) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
